// ===== rtl/tkm_pkg.sv =====
package tkm_pkg;

    // result kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_MOVE    = 2'd2;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_ENABLE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_MODE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_CODES    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_SPEED    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_X_SIGN   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MOUSE_Y_SIGN   = 3'd6;

    localparam int THR_W = 15;

    // decoded sample queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic             mouse_enable;
        logic             relative_mode;
        logic [THR_W-1:0] tilt_threshold;
        logic [31:0]      event_codes;
        logic [6:0]       mouse_speed;
        logic [1:0]       mouse_x_sign;
        logic [1:0]       mouse_y_sign;
    } t_cfg;

    // one decoded sample: up to four key events in emit order, then a move
    typedef struct packed {
        logic [3:0]      kvld;
        logic [3:0]      krel;
        logic [3:0][7:0] kcode;
        logic            mvld;
        logic [7:0]      mx_b;
        logic [7:0]      my_b;
    } t_desc;

endpackage

// ===== rtl/tkm_ifs.sv =====
interface tkm_sample_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] tilt_fwd;
    logic signed [SAMPLE_WIDTH-1:0] tilt_side;
    modport source(output valid, output tilt_fwd, output tilt_side, input ready);
    modport sink(input valid, input tilt_fwd, input tilt_side, output ready);
endinterface

interface tkm_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [7:0]        event_code;
    logic signed [7:0] move_dx;
    logic signed [7:0] move_dy;
    logic              last;
    modport source(output valid, output kind, output event_code, output move_dx,
                   output move_dy, output last, input ready);
    modport sink(input valid, input kind, input event_code, input move_dx,
                 input move_dy, input last, output ready);
endinterface

interface tkm_cfg_if;
    import tkm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/tkm_front.sv =====
module tkm_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_fwd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_side,
    input  tkm_pkg::t_cfg                  i_cfg,
    input  logic                           i_full,
    output logic                           o_push,
    output tkm_pkg::t_desc                 o_desc
);
    import tkm_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int VW = SW + 1;                    // value or delta, never overflows
    localparam int CW = ((VW > 16) ? VW : 16) + 1; // threshold compare width
    localparam int EW = VW + 8;                    // room for the integer byte

    logic          [SW-1:0] r_prev [2];
    logic          [VW-1:0] r_val  [2];
    logic                   r_a_vld;
    logic          [3:0]    r_flags;

    logic          [VW-1:0] n_val  [2];
    logic          [3:0]    n_flags;
    logic          [VW-1:0] w_samp [2];
    logic          [3:0]    w_touch;
    logic          [3:0]    w_tgt;
    logic          [3:0]    w_chg;
    logic          [7:0]    w_byte [2];
    logic signed   [CW-1:0] w_vext [2];
    logic signed   [CW-1:0] w_thr;
    logic          [EW-1:0] w_ext  [2];
    logic                   w_has_res;
    logic                   w_fire;
    logic                   w_accept;

    assign w_accept = i_valid && o_ready;

    // stage A: value or delta against the previous sample
    always_comb begin
        w_samp[0] = {i_fwd[SW-1], i_fwd};
        w_samp[1] = {i_side[SW-1], i_side};
        for (int a = 0; a < 2; a++) begin
            if (i_cfg.relative_mode) begin
                n_val[a] = w_samp[a] - {r_prev[a][SW-1], r_prev[a]};
            end else begin
                n_val[a] = w_samp[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_prev[0] <= '0;
            r_prev[1] <= '0;
        end else begin
            if (w_accept) begin
                r_a_vld <= 1'b1;
            end else if (w_fire) begin
                r_a_vld <= 1'b0;
            end
            if (w_accept && i_cfg.relative_mode) begin
                r_prev[0] <= i_fwd;
                r_prev[1] <= i_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val[0] <= n_val[0];
            r_val[1] <= n_val[1];
        end
    end

    // stage B: classify per axis, flag targets and the move byte
    always_comb begin
        w_thr = {{(CW-THR_W){1'b0}}, i_cfg.tilt_threshold};
        for (int a = 0; a < 2; a++) begin
            w_vext[a] = {{(CW-VW){r_val[a][VW-1]}}, r_val[a]};
            if (i_cfg.relative_mode) begin
                if (r_val[a][VW-1]) begin
                    // negative delta presses side 0 only
                    w_touch[2*a +: 2] = 2'b01;
                    w_tgt[2*a +: 2]   = 2'b01;
                end else if (r_val[a] != '0) begin
                    w_touch[2*a +: 2] = 2'b10;
                    w_tgt[2*a +: 2]   = 2'b10;
                end else begin
                    w_touch[2*a +: 2] = 2'b11;
                    w_tgt[2*a +: 2]   = 2'b00;
                end
            end else begin
                w_touch[2*a +: 2] = 2'b11;
                w_tgt[2*a+1]      = w_vext[a] > w_thr;
                w_tgt[2*a]        = w_vext[a] < -w_thr;
            end
            // integer part truncated toward zero, low byte
            w_ext[a]  = {{8{r_val[a][VW-1]}}, r_val[a]};
            w_byte[a] = w_ext[a][15:8]
                      + {7'd0, w_ext[a][EW-1] && (w_ext[a][7:0] != 8'd0)};
        end
        w_chg = w_touch & (w_tgt ^ r_flags);
        for (int i = 0; i < 4; i++) begin
            n_flags[i] = w_touch[i] ? w_tgt[i] : r_flags[i];
        end
    end

    // slots in emit order: absolute side 1 before side 0, relative side 0 first
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            if (i_cfg.relative_mode) begin
                o_desc.kvld[s]  = w_chg[s];
                o_desc.krel[s]  = !w_tgt[s];
                o_desc.kcode[s] = i_cfg.event_codes[8*s +: 8];
            end else begin
                o_desc.kvld[s]  = w_chg[s ^ 1];
                o_desc.krel[s]  = !w_tgt[s ^ 1];
                o_desc.kcode[s] = i_cfg.event_codes[8*(s ^ 1) +: 8];
            end
        end
        o_desc.mvld = i_cfg.mouse_enable;
        o_desc.mx_b = w_byte[1];
        o_desc.my_b = w_byte[0];
    end

    assign w_has_res = (w_chg != 4'd0) || i_cfg.mouse_enable;
    assign w_fire    = r_a_vld && (!i_full || !w_has_res);
    assign o_push    = r_a_vld && w_has_res && !i_full;
    assign o_ready   = !r_a_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 4'd0;
        end else if (w_fire) begin
            r_flags <= n_flags;
        end
    end

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_desc.kvld != 4'd0) || o_desc.mvld)
        else $error("empty descriptor pushed");

    a_abs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !i_cfg.relative_mode) |=> !(r_flags[0] && r_flags[1])
                                             && !(r_flags[2] && r_flags[3]))
        else $error("both sides of an axis pressed after absolute update");

endmodule

// ===== rtl/tkm_queue.sv =====
module tkm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tkm_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output tkm_pkg::t_desc o_desc,
    output logic           o_empty
);
    import tkm_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CNTW-1:0]  r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    // pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count != '0) && (r_count <= CNTW'(QUEUE_DEPTH)))
        else $error("queue count out of range");

endmodule

// ===== rtl/tkm_back.sv =====
module tkm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tkm_pkg::t_cfg     i_cfg,
    input  logic              i_empty,
    input  tkm_pkg::t_desc    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_code,
    output logic signed [7:0] o_dx,
    output logic signed [7:0] o_dy,
    output logic              o_last
);
    import tkm_pkg::*;

    t_desc       r_cur;
    logic [4:0]  r_pend;
    logic        r_o_vld;
    logic [1:0]  r_kind;
    logic [7:0]  r_code;
    logic [7:0]  r_dx;
    logic [7:0]  r_dy;
    logic        r_last;

    logic [4:0]  w_oh;
    logic [4:0]  w_rest;
    logic        w_load;
    logic [1:0]  n_kind;
    logic [7:0]  n_code;
    logic [7:0]  n_dx;
    logic [7:0]  n_dy;

    // integer byte times speed times direction, wrapped to 8 bits
    function automatic logic [7:0] f_step(input logic [7:0] b, input logic [6:0] spd,
                                          input logic [1:0] sg);
        logic signed [15:0] p;
        logic [7:0]         p8;
        logic [7:0]         r;
        p  = $signed(b) * $signed({1'b0, spd});
        p8 = p[7:0];
        case (sg)
            2'b01:   r = p8;
            2'b11:   r = 8'd0 - p8;
            2'b10:   r = 8'd0 - {p8[6:0], 1'b0};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // lowest pending slot goes next
    assign w_oh   = r_pend & (~r_pend + 5'd1);
    assign w_rest = r_pend & ~w_oh;
    assign w_load = (r_pend != 5'd0) && (!r_o_vld || i_ready);
    assign o_pop  = !i_empty && ((r_pend == 5'd0) || (w_load && (w_rest == 5'd0)));

    always_comb begin
        n_kind = KIND_MOVE;
        n_code = 8'd0;
        n_dx   = 8'd0;
        n_dy   = 8'd0;
        if (w_oh[4]) begin
            n_dx = f_step(r_cur.mx_b, i_cfg.mouse_speed, i_cfg.mouse_x_sign);
            n_dy = f_step(r_cur.my_b, i_cfg.mouse_speed, i_cfg.mouse_y_sign);
        end
        for (int k = 0; k < 4; k++) begin
            if (w_oh[k]) begin
                n_kind = r_cur.krel[k] ? KIND_RELEASE : KIND_PRESS;
                n_code = r_cur.kcode[k];
            end
        end
    end

    // current descriptor and its pending slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 5'd0;
        end else if (o_pop) begin
            r_pend <= {i_head.mvld, i_head.kvld};
        end else if (w_load) begin
            r_pend <= w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_load) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= n_kind;
            r_code <= n_code;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_last <= (w_rest == 5'd0);
        end
    end

    assign o_valid = r_o_vld;
    assign o_kind  = r_kind;
    assign o_code  = r_code;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_last  = r_last;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_pend != 5'd0)
        else $error("popped descriptor without results");

    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && (r_kind != KIND_MOVE)) |-> (r_dx == 8'd0) && (r_dy == 8'd0))
        else $error("key event carries a move step");

endmodule

// ===== rtl/tilt_to_key_event_mapper_unit.sv =====
// Tilt to key event mapper.
// i_sample carries one two-axis accelerometer beat (tilt_fwd, tilt_side, signed
// Q8.8). o_result gives press, release and mouse move beats, one per cycle while the
// receiver is ready, with last set on the final beat caused by a sample; a sample that
// changes no flag with mouse mode off gives no beat. i_cfg writes register i at index
// i and is always ready; write only while no sample is in flight.
// A taken sample beat passes the value/delta register, decode into the queue, the
// descriptor register and the output register before its first result beat is
// valid. Throughput: the output side emits one beat per cycle while the receiver
// is ready, so a sample holds the back end for one beat per result, 1 to 5; a new
// sample is taken every cycle while the four-entry descriptor queue has room.
// The key flags are updated as each sample is decoded, so the front keeps
// going while earlier results drain.
// When the receiver stalls the output register holds its beat; the queue fills
// and then i_sample.ready drops. Reset clears flags, previous samples, queue
// and output valid, and sets the registers to their defaults.
module tilt_to_key_event_mapper_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tkm_sample_if.sink        i_sample,
    tkm_result_if.source      o_result,
    tkm_cfg_if.sink           i_cfg
);
    import tkm_pkg::*;

    t_cfg   r_cfg;
    t_desc  w_push_desc;
    t_desc  w_head;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mouse_enable   <= 1'b0;
            r_cfg.relative_mode  <= 1'b0;
            r_cfg.tilt_threshold <= 15'd768;
            r_cfg.event_codes    <= 32'd0;
            r_cfg.mouse_speed    <= 7'd1;
            r_cfg.mouse_x_sign   <= 2'd1;
            r_cfg.mouse_y_sign   <= 2'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MOUSE_ENABLE:   r_cfg.mouse_enable   <= i_cfg.data[0];
                REG_RELATIVE_MODE:  r_cfg.relative_mode  <= i_cfg.data[0];
                REG_TILT_THRESHOLD: r_cfg.tilt_threshold <= i_cfg.data[THR_W-1:0];
                REG_EVENT_CODES:    r_cfg.event_codes    <= i_cfg.data[31:0];
                REG_MOUSE_SPEED:    r_cfg.mouse_speed    <= i_cfg.data[6:0];
                REG_MOUSE_X_SIGN:   r_cfg.mouse_x_sign   <= i_cfg.data[1:0];
                REG_MOUSE_Y_SIGN:   r_cfg.mouse_y_sign   <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    tkm_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_sample.valid),
        .o_ready (i_sample.ready),
        .i_fwd   (i_sample.tilt_fwd),
        .i_side  (i_sample.tilt_side),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_desc  (w_push_desc)
    );

    tkm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_desc  (w_head),
        .o_empty (w_empty)
    );

    tkm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_kind  (o_result.kind),
        .o_code  (o_result.event_code),
        .o_dx    (o_result.move_dx),
        .o_dy    (o_result.move_dy),
        .o_last  (o_result.last)
    );

endmodule

// ===== verif/tkm_result_checker.sv =====
// Watches the sample, result and register channels of the tilt mapper,
// predicts every result beat and compares it against the DUT output.
module tkm_result_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tkm_sample_if i_sample,
    tkm_result_if i_result,
    tkm_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_samples,
    output int    o_results
);
    import tkm_pkg::*;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        code;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic              last;
    } key_beat_t;

    // shadow of the block's registers and state
    t_cfg                           cfg_shadow;
    logic [3:0]                     key_down;
    logic signed [SAMPLE_WIDTH-1:0] prev_val [2];

    key_beat_t pending_beats[$];
    int        fail_count;
    int        sample_count;
    int        result_count;
    int        pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_samples    = sample_count;
    assign o_results    = result_count;

    initial begin
        fail_count    = 0;
        sample_count  = 0;
        result_count  = 0;
        pending_count = 0;
    end

    // press or release one direction, queueing a beat only on a change
    task automatic set_key(input int idx, input logic press);
        key_beat_t b;
        if (key_down[idx] != press) begin
            key_down[idx] = press;
            b.kind = press ? KIND_PRESS : KIND_RELEASE;
            b.code = cfg_shadow.event_codes[8*idx +: 8];
            b.dx   = '0;
            b.dy   = '0;
            b.last = 1'b0;
            pending_beats.push_back(b);
        end
    endtask

    // integer part (toward zero), wrapped to 8 bits, scaled by gain and direction
    function automatic logic [7:0] mouse_step(input longint v, input logic signed [1:0] dir);
        longint            whole;
        logic signed [7:0] b;
        longint            p;
        whole = v / 256;
        b     = whole[7:0];
        p     = longint'(b) * longint'(cfg_shadow.mouse_speed) * longint'(dir);
        return p[7:0];
    endfunction

    // expected beats for one accepted sample
    task automatic map_tilt_sample(input logic signed [SAMPLE_WIDTH-1:0] fwd,
                                   input logic signed [SAMPLE_WIDTH-1:0] side);
        longint    v [2];
        longint    d;
        longint    thr;
        int        base;
        key_beat_t mv;
        base = pending_beats.size();
        v[0] = fwd;
        v[1] = side;
        if (cfg_shadow.relative_mode) begin
            for (int a = 0; a < 2; a++) begin
                d           = v[a] - longint'(prev_val[a]);
                prev_val[a] = v[a][SAMPLE_WIDTH-1:0];
                v[a]        = d;
            end
            // a move presses one side and leaves the other as it was
            for (int a = 0; a < 2; a++) begin
                if (v[a] > 0) begin
                    set_key(2*a + 1, 1'b1);
                end else if (v[a] < 0) begin
                    set_key(2*a, 1'b1);
                end else begin
                    set_key(2*a, 1'b0);
                    set_key(2*a + 1, 1'b0);
                end
            end
        end else begin
            thr = longint'(cfg_shadow.tilt_threshold);
            for (int a = 0; a < 2; a++) begin
                set_key(2*a + 1, v[a] > thr);
                set_key(2*a, v[a] < -thr);
            end
        end
        if (cfg_shadow.mouse_enable) begin
            mv.kind = KIND_MOVE;
            mv.code = '0;
            mv.dx   = mouse_step(v[1], cfg_shadow.mouse_x_sign);
            mv.dy   = mouse_step(v[0], cfg_shadow.mouse_y_sign);
            mv.last = 1'b0;
            pending_beats.push_back(mv);
        end
        if (pending_beats.size() > base)
            pending_beats[pending_beats.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        key_beat_t want;
        if (!i_rst_n) begin
            cfg_shadow.mouse_enable   = 1'b0;
            cfg_shadow.relative_mode  = 1'b0;
            cfg_shadow.tilt_threshold = 15'd768;
            cfg_shadow.event_codes    = '0;
            cfg_shadow.mouse_speed    = 7'd1;
            cfg_shadow.mouse_x_sign   = 2'd1;
            cfg_shadow.mouse_y_sign   = 2'd1;
            key_down                  = '0;
            prev_val[0]               = '0;
            prev_val[1]               = '0;
            pending_beats.delete();
        end else begin
            // result beat against the oldest expectation
            if (i_result.valid && i_result.ready) begin
                result_count++;
                if (pending_beats.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %s", $time,
                             $sformatf("kind %0d code %0d dx %0d dy %0d last %0d",
                                       i_result.kind, i_result.event_code, i_result.move_dx,
                                       i_result.move_dy, i_result.last));
                    fail_count++;
                end else begin
                    want = pending_beats.pop_front();
                    check_field("kind", want.kind, i_result.kind);
                    check_field("event_code", want.code, i_result.event_code);
                    check_field("move_dx", want.dx, i_result.move_dx);
                    check_field("move_dy", want.dy, i_result.move_dy);
                    check_field("last", want.last, i_result.last);
                end
            end

            // register write
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_MOUSE_ENABLE:   cfg_shadow.mouse_enable   = i_cfg.data[0];
                    REG_RELATIVE_MODE:  cfg_shadow.relative_mode  = i_cfg.data[0];
                    REG_TILT_THRESHOLD: cfg_shadow.tilt_threshold = i_cfg.data[THR_W-1:0];
                    REG_EVENT_CODES:    cfg_shadow.event_codes    = i_cfg.data[31:0];
                    REG_MOUSE_SPEED:    cfg_shadow.mouse_speed    = i_cfg.data[6:0];
                    REG_MOUSE_X_SIGN:   cfg_shadow.mouse_x_sign   = i_cfg.data[1:0];
                    REG_MOUSE_Y_SIGN:   cfg_shadow.mouse_y_sign   = i_cfg.data[1:0];
                    default: ;
                endcase
            end

            // sample beat
            if (i_sample.valid && i_sample.ready) begin
                sample_count++;
                map_tilt_sample(i_sample.tilt_fwd, i_sample.tilt_side);
            end
        end
        pending_count = pending_beats.size();
    end

endmodule

// ===== verif/tilt_to_key_event_mapper_unit_tb.sv =====
module tilt_to_key_event_mapper_unit_tb;
    import tkm_pkg::*;

    localparam int SW          = 16;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 12;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 26;

    // index past the register list, writes to it must do nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic i_clk;
    logic i_rst_n;

    tkm_sample_if #(.SAMPLE_WIDTH(SW)) smp_if ();
    tkm_result_if                      res_if ();
    tkm_cfg_if                         cfg_if ();

    int chk_fails;
    int chk_pending;
    int chk_samples;
    int chk_results;

    // stimulus controls: 0 means no idling, n means one chance in n per beat
    int   tx_gap_odds;
    int   rx_stall_odds;
    t_cfg cur_cfg;
    int   last_fwd;
    int   last_side;

    tilt_to_key_event_mapper_unit #(.SAMPLE_WIDTH(SW)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    tkm_result_checker #(.SAMPLE_WIDTH(SW)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (smp_if),
        .i_result     (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_samples    (chk_samples),
        .o_results    (chk_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side back-pressure in random bursts, set by rx_stall_odds
    initial begin
        int hold;
        hold         = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                res_if.ready = 1'b0;
                hold--;
            end else if (rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1) begin
                res_if.ready = 1'b0;
                hold         = $urandom_range(0, 11);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted beat
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // write all registers, upper data bits sometimes junk; block must be idle
    task automatic apply_config(input t_cfg c);
        logic [CFG_INDEX_W-1:0] idx [7];
        logic [31:0]            val [7];
        int                     wid [7];
        logic [31:0]            data;
        idx = '{REG_MOUSE_ENABLE, REG_RELATIVE_MODE, REG_TILT_THRESHOLD, REG_EVENT_CODES,
                REG_MOUSE_SPEED, REG_MOUSE_X_SIGN, REG_MOUSE_Y_SIGN};
        val = '{32'(c.mouse_enable), 32'(c.relative_mode), 32'(c.tilt_threshold),
                c.event_codes, 32'(c.mouse_speed), 32'(c.mouse_x_sign), 32'(c.mouse_y_sign)};
        wid = '{1, 1, THR_W, 32, 7, 2, 2};
        for (int i = 0; i < 8; i++) begin
            if (i == 7) begin
                if ($urandom_range(0, 1) == 0)
                    break;
                cfg_if.index = REG_UNUSED;
                data         = $urandom;
            end else begin
                cfg_if.index = idx[i];
                data         = val[i];
                if (wid[i] < 32 && $urandom_range(0, 1) == 1)
                    data = data | ($urandom << wid[i]);
            end
            cfg_if.data  = data;
            cfg_if.valid = 1'b1;
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        cfg_if.valid = 1'b0;
        cur_cfg      = c;
    endtask

    task automatic set_cfg(input logic me, input logic rel, input int thr, input logic [31:0] codes,
                           input int speed, input logic [1:0] xs, input logic [1:0] ys);
        t_cfg c;
        c.mouse_enable   = me;
        c.relative_mode  = rel;
        c.tilt_threshold = THR_W'(thr);
        c.event_codes    = codes;
        c.mouse_speed    = 7'(speed);
        c.mouse_x_sign   = xs;
        c.mouse_y_sign   = ys;
        apply_config(c);
    endtask

    // one sample beat, with an optional gap before it; valid stays high after
    task automatic send_sample(input int fwd, input int side);
        if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            smp_if.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        smp_if.valid     = 1'b1;
        smp_if.tilt_fwd  = SW'(fwd);
        smp_if.tilt_side = SW'(side);
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        last_fwd  = fwd;
        last_side = side;
    endtask

    // drain all expected beats, then let beat-less samples clear the pipe
    task automatic settle();
        smp_if.valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // axis value biased toward the threshold edges or small deltas
    function automatic int pick_axis(input int prev_v);
        longint v;
        longint t;
        t = longint'(cur_cfg.tilt_threshold);
        case ($urandom_range(0, 7))
            0, 1: v = longint'($urandom_range(0, 65535)) - 32768;
            2, 3: begin
                if (cur_cfg.relative_mode) begin
                    v = longint'(prev_v) + longint'($urandom_range(0, 1200)) - 600;
                end else begin
                    v = t - 1 + longint'($urandom_range(0, 2));
                    if ($urandom_range(0, 1) == 1)
                        v = -v;
                end
            end
            4: v = cur_cfg.relative_mode ? longint'(prev_v) : 0;
            5: v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            default: v = longint'($urandom_range(0, 2047)) - 1024;
        endcase
        if (v > 32767 || v < -32768)
            v = longint'($urandom_range(0, 65535)) - 32768;
        return int'(v);
    endfunction

    initial begin
        t_cfg c;
        smp_if.valid     = 1'b0;
        smp_if.tilt_fwd  = '0;
        smp_if.tilt_side = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        tx_gap_odds      = 4;
        rx_stall_odds    = 5;
        last_fwd         = 0;
        last_side        = 0;
        i_rst_n          = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // absolute mode, keys only, default threshold
        set_cfg(1'b0, 1'b0, 768, 32'hD4C3B2A1, 1, 2'b01, 2'b01);
        send_sample(0, 0);
        send_sample(769, 0);
        send_sample(768, 0);
        send_sample(-769, -769);
        send_sample(32767, 32767);
        send_sample(-32768, -32768);
        send_sample(0, 0);
        settle();

        // zero threshold, mouse on, full gain, -1 and -2 direction patterns
        set_cfg(1'b1, 1'b0, 0, 32'h5A6B7C8D, 127, 2'b11, 2'b10);
        send_sample(0, 0);
        send_sample(1, -1);
        send_sample(255, -255);
        send_sample(256, -256);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        settle();

        // maximum threshold, zero gain, zero direction
        set_cfg(1'b1, 1'b0, 32767, 32'hFFFFFFFF, 0, 2'b00, 2'b01);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(100, -100);
        settle();

        // delta mode: zero, repeated, and full-scale swings that wrap the step
        set_cfg(1'b1, 1'b1, 768, 32'h01020304, 1, 2'b01, 2'b01);
        send_sample(0, 0);
        send_sample(300, -300);
        send_sample(300, -300);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        settle();

        // random phases; the last runs without idling on either side
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == N_PHASES - 1) begin
                tx_gap_odds   = 0;
                rx_stall_odds = 0;
            end else begin
                tx_gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
                rx_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            end
            c.mouse_enable  = 1'($urandom_range(0, 1));
            c.relative_mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       c.tilt_threshold = '0;
                1:       c.tilt_threshold = 15'h7FFF;
                default: c.tilt_threshold = THR_W'($urandom_range(0, 4095));
            endcase
            c.event_codes = $urandom;
            case ($urandom_range(0, 3))
                0:       c.mouse_speed = '0;
                1:       c.mouse_speed = 7'h7F;
                default: c.mouse_speed = 7'($urandom_range(1, 126));
            endcase
            c.mouse_x_sign = 2'($urandom_range(0, 3));
            c.mouse_y_sign = 2'($urandom_range(0, 3));
            apply_config(c);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_axis(last_fwd), pick_axis(last_side));
            settle();
        end

        $display("Checked %0d samples and %0d result beats: directed edges, then %0d random phases",
                 chk_samples, chk_results, N_PHASES);
        $display("Mismatches found: %0d", chk_fails);
        if (chk_fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tkm_pkg.sv
rtl/tkm_ifs.sv
rtl/tkm_front.sv
rtl/tkm_queue.sv
rtl/tkm_back.sv
rtl/tilt_to_key_event_mapper_unit.sv
verif/tkm_result_checker.sv
verif/tilt_to_key_event_mapper_unit_tb.sv
